>>> hw/rtl/scv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scv_pkg;

    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 8'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hF5;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hA5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_SUM    = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [BYTE_W-1:0] payload_length;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/scv_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module scv_parser
    import scv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_in_item          i_item,
    input  wire logic [BYTE_W-1:0] i_header_first,
    input  wire logic [BYTE_W-1:0] i_header_second,
    output t_result                o_result
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SUM_LO  = 3'd1,
        PH_SUM_HI  = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase             r_phase,        n_phase;
    logic [SUM_W-1:0]   r_expected_sum, n_expected_sum;
    logic [SUM_W-1:0]   r_running_sum,  n_running_sum;
    logic [BYTE_W-1:0]  r_bytes_left,   n_bytes_left;
    logic [BYTE_W-1:0]  r_length_seen,  n_length_seen;
    logic [SUM_W-1:0]   sum_plus;

    assign sum_plus = r_running_sum + {{(SUM_W-BYTE_W){1'b0}}, i_item.rx_byte};

    always_comb begin
        n_phase        = r_phase;
        n_expected_sum = r_expected_sum;
        n_running_sum  = r_running_sum;
        n_bytes_left   = r_bytes_left;
        n_length_seen  = r_length_seen;
        o_result       = '{valid: 1'b0, status: ST_OK, payload_length: '0};
        if (i_item.frame_start) begin
            n_expected_sum = '0;
            n_running_sum  = '0;
            n_bytes_left   = '0;
            n_length_seen  = '0;
            if (i_item.rx_byte == i_header_first || i_item.rx_byte == i_header_second) begin
                n_phase = PH_SUM_LO;
            end else begin
                n_phase  = PH_IDLE;
                o_result = '{valid: 1'b1, status: ST_BAD_HEADER, payload_length: '0};
            end
        end else begin
            case (r_phase)
                PH_SUM_LO: begin
                    n_expected_sum = {{(SUM_W-BYTE_W){1'b0}}, i_item.rx_byte};
                    n_phase        = PH_SUM_HI;
                end
                PH_SUM_HI: begin
                    n_expected_sum = {i_item.rx_byte, r_expected_sum[BYTE_W-1:0]};
                    n_phase        = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_length_seen = i_item.rx_byte;
                    n_bytes_left  = i_item.rx_byte;
                    n_running_sum = '0;
                    if (i_item.rx_byte == '0) begin
                        // empty payload: compare against a zero sum
                        n_phase  = PH_IDLE;
                        o_result = '{valid: 1'b1,
                                     status: (r_expected_sum == '0) ? ST_OK : ST_BAD_SUM,
                                     payload_length: i_item.rx_byte};
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_running_sum = sum_plus;
                    n_bytes_left  = r_bytes_left - 1'b1;
                    if (r_bytes_left == BYTE_W'(1)) begin
                        n_phase  = PH_IDLE;
                        o_result = '{valid: 1'b1,
                                     status: (sum_plus == r_expected_sum) ? ST_OK : ST_BAD_SUM,
                                     payload_length: r_length_seen};
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        if (!i_step) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_expected_sum <= '0;
            r_running_sum  <= '0;
            r_bytes_left   <= '0;
            r_length_seen  <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_expected_sum <= n_expected_sum;
            r_running_sum  <= n_running_sum;
            r_bytes_left   <= n_bytes_left;
            r_length_seen  <= n_length_seen;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scv_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module scv_out_reg
    import scv_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_result                i_result,
    output logic                        o_free,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_TDATA_W-1:0]      o_tdata
);

    logic              r_valid, n_valid;
    t_status           r_status;
    logic [BYTE_W-1:0] r_length;

    // register is free when empty or being drained this cycle
    assign o_free  = !r_valid || i_tready;
    assign n_valid = o_free ? i_result.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_status <= i_result.status;
            r_length <= i_result.payload_length;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {{(OUT_TDATA_W-STATUS_W-BYTE_W){1'b0}}, r_length, r_status};

endmodule

`default_nettype wire

>>> hw/rtl/sum_checked_frame_validator.sv
// results pass through the input register and then the result register before reaching the output
// throughput: one byte per cycle unless the output stalls; one add and compare per byte
// bytes that give no result are consumed without an output transaction
// reset: synchronous, active low; clears the parse state and both pipeline valids,
// and loads the header registers with 0xF5 and 0xA5
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_validator
    import scv_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [BYTE_W-1:0]      i_s_tdata,   // [7:0] rx_byte
    input  wire logic                   i_s_tuser,   // [0] frame_start
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [1:0] status, [9:2] payload_length
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [BYTE_W-1:0]      i_cfg_data
);

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic [BYTE_W-1:0] r_header_first;
    logic [BYTE_W-1:0] r_header_second;
    logic              out_free;
    logic              step;
    t_result           result;

    assign step        = r_in_valid && out_free;
    assign o_s_tready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item <= '{rx_byte: i_s_tdata, frame_start: i_s_tuser};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= HEADER_FIRST_RST;
            r_header_second <= HEADER_SECOND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scv_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (r_in_item),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_result        (result)
    );

    scv_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_free   (out_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata)
    );

    // a bad header always reports a zero length
    a_bad_header_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[STATUS_W-1:0] == ST_BAD_HEADER)
            |-> o_m_tdata[STATUS_W+BYTE_W-1:STATUS_W] == '0)
        else $error("bad header with nonzero length");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[STATUS_W-1:0] != 2'd3)
        else $error("unused status code on output");

    // a stalled input register keeps its byte until the parser takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register lost a byte while stalled");

    // a result only appears when a byte was parsed the cycle before
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid && !step) |=> !o_m_tvalid)
        else $error("result appeared without a parsed byte");

endmodule

`default_nettype wire
